// File: rtl/sha1he_pkg.sv
`default_nettype none

package sha1he_pkg;

  // Five working or chaining words of the hash state
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } words_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  // Standard initial chaining value
  localparam logic [31:0] INIT_A = 32'h6745_2301;
  localparam logic [31:0] INIT_B = 32'hEFCD_AB89;
  localparam logic [31:0] INIT_C = 32'h98BA_DCFE;
  localparam logic [31:0] INIT_D = 32'h1032_5476;
  localparam logic [31:0] INIT_E = 32'hC3D2_E1F0;

  // Round constants, one per group of twenty rounds
  localparam logic [31:0] K_GRP0 = 32'h5A82_7999;
  localparam logic [31:0] K_GRP1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K_GRP2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K_GRP3 = 32'hCA62_C1D6;

  localparam int unsigned ROUNDS = 80;
  localparam int unsigned RND_W  = 7;

  // Padding marker byte
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_E    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CNT = 3'd5;

  // Index of the last digest word
  localparam logic [2:0] LAST_WORD = 3'd4;

  // Keep the leading n bits of a partial byte and append the 1 marker bit
  function automatic logic [7:0] partial_byte(input logic [7:0] b, input logic [3:0] n);
    logic [7:0] keep;
    logic [7:0] one;
    keep = 8'hFF << (4'd8 - n);
    one  = PAD_MARK >> n;
    return (b & keep) | one;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sha1_hash_engine.sv
// Non-final byte: shifted into the block window; the byte that fills a 64-byte block
// starts compression (80 rounds through one round unit plus one chaining add).
// Final item: up to 72 padding bytes, one per cycle except while a block compresses;
// then five digest words, one per transfer. Input stall is high from a block fill
// to its chaining add, and from a final item until the last digest word is taken.
// Reset (asynchronous) restores the standard initial words, a zero start count and idle.
`default_nettype none

module sha1_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  msg_byte_i,
  input  wire logic [3:0]  valid_bits_i,
  input  wire logic        final_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_word_o,
  output logic             digest_last_o
);

  sha1he_pkg::state_e state_q, state_d;

  sha1he_pkg::words_t init_q, init_d;
  logic [63:0]        start_cnt_q, start_cnt_d;

  sha1he_pkg::words_t chain_q, chain_d;
  sha1he_pkg::words_t work_q, work_d;
  sha1he_pkg::words_t round_nxt;
  logic [511:0]       win_q, win_d;
  logic [63:0]        total_q, total_d;
  logic [5:0]         fill_q, fill_d;
  logic [sha1he_pkg::RND_W-1:0] rnd_q, rnd_d;
  logic [2:0]         oidx_q, oidx_d;
  logic               active_q, active_d;
  logic               pad_q, pad_d;
  logic               need80_q, need80_d;
  logic               len_q, len_d;
  logic               done_q, done_d;

  logic [3:0]  nbits;
  logic [5:0]  fill_base;
  logic [63:0] total_base;
  logic        push;
  logic [7:0]  push_byte;
  logic [31:0] sched_w;
  logic [31:0] sched_x;
  logic [7:0]  len_byte;

  // Clamp the bit count to a full byte
  assign nbits = valid_bits_i[3] ? 4'd8 : valid_bits_i;

  // Next schedule word from the window taps, oldest word at the top
  assign sched_x = win_q[511:480] ^ win_q[447:416] ^ win_q[255:224] ^ win_q[95:64];
  assign sched_w = (rnd_q < 7'd16) ? win_q[511:480] : {sched_x[30:0], sched_x[31]};

  // Length byte for the current block position, most significant first
  assign len_byte = 8'(total_q >> {~fill_q[2:0], 3'b000});

  sha1he_round u_round (
    .cur_i (work_q),
    .w_i   (sched_w),
    .rnd_i (rnd_q),
    .nxt_o (round_nxt)
  );

  // Configuration writes
  always_comb begin
    init_d      = init_q;
    start_cnt_d = start_cnt_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sha1he_pkg::CFG_INIT_A:    init_d.a    = cfg_data_i[31:0];
        sha1he_pkg::CFG_INIT_B:    init_d.b    = cfg_data_i[31:0];
        sha1he_pkg::CFG_INIT_C:    init_d.c    = cfg_data_i[31:0];
        sha1he_pkg::CFG_INIT_D:    init_d.d    = cfg_data_i[31:0];
        sha1he_pkg::CFG_INIT_E:    init_d.e    = cfg_data_i[31:0];
        sha1he_pkg::CFG_START_CNT: start_cnt_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '{a: sha1he_pkg::INIT_A, b: sha1he_pkg::INIT_B,
                       c: sha1he_pkg::INIT_C, d: sha1he_pkg::INIT_D,
                       e: sha1he_pkg::INIT_E};
      start_cnt_q <= '0;
    end else begin
      init_q      <= init_d;
      start_cnt_q <= start_cnt_d;
    end
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d    = state_q;
    chain_d    = chain_q;
    work_d     = work_q;
    win_d      = win_q;
    total_d    = total_q;
    fill_d     = fill_q;
    rnd_d      = rnd_q;
    oidx_d     = oidx_q;
    active_d   = active_q;
    pad_d      = pad_q;
    need80_d   = need80_q;
    len_d      = len_q;
    done_d     = done_q;
    push       = 1'b0;
    push_byte  = 8'h00;
    fill_base  = fill_q;
    total_base = total_q;

    unique case (state_q)
      sha1he_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          // Start of a message loads the configured chaining value and count
          active_d = 1'b1;
          if (!active_q) begin
            chain_d    = init_q;
            fill_base  = '0;
            total_base = start_cnt_q;
          end
          fill_d  = fill_base;
          total_d = total_base;
          if (!final_item_i) begin
            if (nbits != 4'd0) begin
              push      = 1'b1;
              push_byte = msg_byte_i;
              total_d   = total_base + 64'd8;
            end
          end else begin
            push     = 1'b1;
            active_d = 1'b0;
            pad_d    = 1'b1;
            len_d    = 1'b0;
            done_d   = 1'b0;
            need80_d = (nbits == 4'd8);
            total_d  = total_base + 64'(nbits);
            if (nbits == 4'd8) begin
              push_byte = msg_byte_i;
            end else if (nbits == 4'd0) begin
              push_byte = sha1he_pkg::PAD_MARK;
            end else begin
              push_byte = sha1he_pkg::partial_byte(msg_byte_i, nbits);
            end
            state_d = sha1he_pkg::ST_PAD;
          end
        end
      end

      sha1he_pkg::ST_PAD: begin
        // Marker if not yet placed, then zeros up to position 56, then the length
        push = 1'b1;
        if (need80_q) begin
          push_byte = sha1he_pkg::PAD_MARK;
          need80_d  = 1'b0;
        end else if (len_q || (fill_q == 6'd56)) begin
          push_byte = len_byte;
          len_d     = 1'b1;
          if (fill_q == 6'd63) begin
            done_d = 1'b1;
          end
        end
      end

      sha1he_pkg::ST_ROUND: begin
        work_d = round_nxt;
        win_d  = {win_q[479:0], sched_w};
        rnd_d  = rnd_q + 7'd1;
        if (rnd_q == 7'(sha1he_pkg::ROUNDS - 1)) begin
          state_d = sha1he_pkg::ST_ADD;
        end
      end

      sha1he_pkg::ST_ADD: begin
        chain_d.a = chain_q.a + work_q.a;
        chain_d.b = chain_q.b + work_q.b;
        chain_d.c = chain_q.c + work_q.c;
        chain_d.d = chain_q.d + work_q.d;
        chain_d.e = chain_q.e + work_q.e;
        if (done_q) begin
          state_d = sha1he_pkg::ST_OUT;
          oidx_d  = '0;
          pad_d   = 1'b0;
          done_d  = 1'b0;
          len_d   = 1'b0;
        end else if (pad_q) begin
          state_d = sha1he_pkg::ST_PAD;
        end else begin
          state_d = sha1he_pkg::ST_IDLE;
        end
      end

      sha1he_pkg::ST_OUT: begin
        // Advance on each word transfer
        if (!out_stall_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == sha1he_pkg::LAST_WORD) begin
            state_d = sha1he_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = sha1he_pkg::ST_IDLE;
    endcase

    // Shift a byte into the block window; a full block starts compression
    if (push) begin
      win_d  = {win_q[503:0], push_byte};
      fill_d = fill_base + 6'd1;
      if (fill_base == 6'd63) begin
        state_d = sha1he_pkg::ST_ROUND;
        rnd_d   = '0;
        work_d  = chain_q;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha1he_pkg::ST_IDLE;
      fill_q   <= '0;
      rnd_q    <= '0;
      oidx_q   <= '0;
      active_q <= 1'b0;
      pad_q    <= 1'b0;
      need80_q <= 1'b0;
      len_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      rnd_q    <= rnd_d;
      oidx_q   <= oidx_d;
      active_q <= active_d;
      pad_q    <= pad_d;
      need80_q <= need80_d;
      len_q    <= len_d;
      done_q   <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chain_q <= chain_d;
    work_q  <= work_d;
    win_q   <= win_d;
    total_q <= total_d;
  end

  // Output side
  assign in_stall_o    = (state_q != sha1he_pkg::ST_IDLE);
  assign out_valid_o   = (state_q == sha1he_pkg::ST_OUT);
  assign digest_last_o = (oidx_q == sha1he_pkg::LAST_WORD);

  always_comb begin
    case (oidx_q)
      3'd0:    digest_word_o = chain_q.a;
      3'd1:    digest_word_o = chain_q.b;
      3'd2:    digest_word_o = chain_q.c;
      3'd3:    digest_word_o = chain_q.d;
      default: digest_word_o = chain_q.e;
    endcase
  end

  // Input and output never open together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input ready while digest is pending");

  // Round counter stays inside the round range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1he_pkg::ST_ROUND) |-> (rnd_q < 7'(sha1he_pkg::ROUNDS)))
    else $error("round counter out of range");

  // Last digest word transfer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && digest_last_o) |=> (state_q == sha1he_pkg::ST_IDLE))
    else $error("no return to idle after last digest word");

  // Length bytes occupy only the tail of a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1he_pkg::ST_PAD && len_q) |-> (fill_q[5:3] == 3'b111))
    else $error("length field outside block tail");

  // Compression completes in the add step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1he_pkg::ST_ROUND && rnd_q == 7'(sha1he_pkg::ROUNDS - 1))
      |=> (state_q == sha1he_pkg::ST_ADD))
    else $error("compression did not end after last round");

endmodule

`default_nettype wire

// File: rtl/sha1he_round.sv
`default_nettype none

module sha1he_round (
  input  wire sha1he_pkg::words_t                 cur_i,
  input  wire logic [31:0]                        w_i,
  input  wire logic [sha1he_pkg::RND_W-1:0]       rnd_i,
  output sha1he_pkg::words_t                      nxt_o
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  // Pick the round function and constant for this group of rounds
  always_comb begin
    if (rnd_i < 7'd20) begin
      f = (cur_i.b & cur_i.c) ^ (~cur_i.b & cur_i.d);
      k = sha1he_pkg::K_GRP0;
    end else if (rnd_i < 7'd40) begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = sha1he_pkg::K_GRP1;
    end else if (rnd_i < 7'd60) begin
      f = (cur_i.b & cur_i.c) ^ (cur_i.b & cur_i.d) ^ (cur_i.c & cur_i.d);
      k = sha1he_pkg::K_GRP2;
    end else begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = sha1he_pkg::K_GRP3;
    end
  end

  // Combine and rotate the working words
  assign t = {cur_i.a[26:0], cur_i.a[31:27]} + f + cur_i.e + k + w_i;

  assign nxt_o.a = t;
  assign nxt_o.b = cur_i.a;
  assign nxt_o.c = {cur_i.b[1:0], cur_i.b[31:2]};
  assign nxt_o.d = cur_i.c;
  assign nxt_o.e = cur_i.d;

endmodule

`default_nettype wire
